// ----- rtl/core/tat_pkg.sv -----
// Package for the tween animation table: actions, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package tat_pkg;
  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_RDW, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_EMIT,
    ST_SHIFT, ST_RESP
  } state_e;

  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  subject;
    logic [31:0] start;
    logic [15:0] duration;
    logic [31:0] initial_v;
    logic [31:0] target_v;
  } entry_t;

  typedef struct packed {
    logic cap_in;     // latch input item
    logic rd;         // read entry at index
    logic load_e;     // latch read entry, start divider
    logic div_step;   // one divider step
    logic mul1;
    logic mul2;
    logic mul3;
    logic wr_push;    // write pushed entry at count
    logic shift_wr;   // write held entry at write index
  } dp_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       done_e;   // entry finishes now
    logic       tag_hit;
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/tween_animation_table.sv -----
// Tween animation table: ordered tween list with smoothstep easing.
// An idle action, or a request on an empty table, only returns a response. A push
// writes the new entry; a removal reads each entry and compacts the kept ones. An
// update takes a running tween through a 16-step restoring divider and three multiply
// stages; a finished one skips the divider steps. One item at a time; output stalls wait.
// Reset clears the entry count and controller; the table holds no reset.
`default_nettype none
module tween_animation_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire  logic         clk_i,
  input  wire  logic         rst_ni,
  input  wire  logic         s_axis_tvalid,
  output logic               s_axis_tready,
  // action[1:0], tag, subject id, start value, end value, start tick,
  // duration, current tick, zero fill to 168 bits
  input  wire  logic [167:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire  logic         m_axis_tready,
  // out_subject[7:0], out_value[39:8]
  output logic [39:0]        m_axis_tdata,
  // valid_value, finished, overflow
  output logic [2:0]         m_axis_tuser,
  output logic               m_axis_tlast
);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  tat_pkg::dp_cmd_t cmd;
  tat_pkg::dp_sts_t sts;
  logic [IW-1:0] rd_idx, wr_idx, cnt_idx;
  logic [7:0] subj;
  logic [31:0] value;
  logic vv, fin, ovf;

  tat_ctrl #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .action_i(s_axis_tdata[1:0]), .sts_i(sts), .cmd_o(cmd),
    .rd_idx_o(rd_idx), .wr_idx_o(wr_idx), .cnt_idx_o(cnt_idx),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .o_vv_o(vv), .o_fin_o(fin), .o_ovf_o(ovf), .o_last_o(m_axis_tlast)
  );

  tat_datapath #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_dp (
    .clk_i, .cmd_i(cmd), .rd_idx_i(rd_idx), .wr_idx_i(wr_idx),
    .cnt_idx_i(cnt_idx), .in_data_i(s_axis_tdata), .sts_o(sts),
    .subj_o(subj), .value_o(value)
  );

  // Result fields are zero on non-animation responses.
  assign m_axis_tdata = vv ? {value, subj} : 40'd0;
  assign m_axis_tuser = {ovf, fin, vv};
endmodule
`default_nettype wire

// ----- rtl/core/tat_datapath.sv -----
// Datapath of the tween table: entry memory, restoring divider, easing
// multiplies. Depends on tat_pkg.
`default_nettype none
module tat_datapath #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW = 4
) (
  input  wire  logic            clk_i,
  input  wire  tat_pkg::dp_cmd_t cmd_i,
  input  wire  logic [IW-1:0]   rd_idx_i,
  input  wire  logic [IW-1:0]   wr_idx_i,
  input  wire  logic [IW-1:0]   cnt_idx_i,
  input  wire  logic [167:0]    in_data_i,
  output tat_pkg::dp_sts_t      sts_o,
  output logic [7:0]            subj_o,
  output logic [31:0]           value_o
);
  tat_pkg::entry_t mem [DEPTH];
  tat_pkg::entry_t rd_q, ent_q;
  logic [167:0]    in_q;
  logic [15:0]     t_q;
  logic [16:0]     rem_q;
  logic [4:0]      dcnt_q;
  logic [31:0]     tt_q;
  logic [17:0]     k_q;
  logic [31:0]     s_q;
  logic [49:0]     prod_q;
  logic [32:0]     diff_q;
  logic            fin_q;

  wire [31:0] in_now = in_q[161:130];
  tat_pkg::entry_t in_e;
  assign in_e.tag = in_q[9:2];
  assign in_e.subject = in_q[17:10];
  assign in_e.initial_v = in_q[49:18];
  assign in_e.target_v = in_q[81:50];
  assign in_e.start = in_q[113:82];
  assign in_e.duration = in_q[129:114];

  // Memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_push) mem[cnt_idx_i] <= in_e;
    else if (cmd_i.shift_wr) mem[wr_idx_i] <= ent_q;
    if (cmd_i.rd) rd_q <= mem[rd_idx_i];
  end

  // Elapsed time, clamped; remainder trial subtraction.
  logic [31:0] elap_d;
  logic [17:0] trial;
  assign elap_d = (in_now >= rd_q.start) ? in_now - rd_q.start : 32'd0;
  assign trial = {rem_q, 1'b0} - {2'b0, ent_q.duration};

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) in_q <= in_data_i;
    if (cmd_i.load_e) begin
      ent_q  <= rd_q;
      fin_q  <= (rd_q.duration == 16'd0) || (elap_d >= {16'd0, rd_q.duration});
      rem_q  <= {1'b0, elap_d[15:0]};
      t_q    <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      // elapsed < duration here, so remainder starts as elapsed.
      if (!trial[17]) begin
        rem_q <= trial[16:0];
        t_q   <= {t_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[15:0], 1'b0};
        t_q   <= {t_q[14:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 5'd1;
    end
    if (cmd_i.mul1) begin
      tt_q   <= {16'd0, t_q} * {16'd0, t_q};
      k_q    <= 18'd196608 - {1'b0, t_q, 1'b0};
      diff_q <= {ent_q.target_v[31], ent_q.target_v} - {ent_q.initial_v[31], ent_q.initial_v};
    end
    if (cmd_i.mul2) s_q <= 32'((({18'd0, tt_q} * {32'd0, k_q}) >> 32));
    if (cmd_i.mul3) prod_q <= 50'($signed(diff_q) * $signed({1'b0, s_q[16:0]}));
  end

  assign sts_o.div_done = dcnt_q == 5'd16;
  assign sts_o.done_e = fin_q;
  assign sts_o.tag_hit = rd_q.tag == in_q[9:2];
  assign subj_o = ent_q.subject;
  assign value_o = fin_q ? ent_q.target_v
                         : ent_q.initial_v + prod_q[47:16];
endmodule
`default_nettype wire

// ----- rtl/core/tat_ctrl.sv -----
// Controller of the tween table: sequences push, update walk and removal.
// Depends on tat_pkg.
`default_nettype none
module tat_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW = 4
) (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  logic            in_valid_i,
  output logic                  in_ready_o,
  input  wire  logic [1:0]      action_i,
  input  wire  tat_pkg::dp_sts_t sts_i,
  output tat_pkg::dp_cmd_t      cmd_o,
  output logic [IW-1:0]         rd_idx_o,
  output logic [IW-1:0]         wr_idx_o,
  output logic [IW-1:0]         cnt_idx_o,
  output logic                  out_valid_o,
  input  wire  logic            out_ready_i,
  output logic                  o_vv_o,
  output logic                  o_fin_o,
  output logic                  o_ovf_o,
  output logic                  o_last_o
);
  tat_pkg::state_e st_q, st_d;
  logic [IW:0] cnt_q, cnt_d, ri_q, ri_d, wi_q, wi_d;
  tat_pkg::action_e act_q, act_d;
  logic ovf_q, ovf_d;

  assign rd_idx_o = ri_q[IW-1:0];
  assign wr_idx_o = wi_q[IW-1:0];
  assign cnt_idx_o = cnt_q[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tat_pkg::ST_IDLE;
      cnt_q <= '0; ri_q <= '0; wi_q <= '0;
      act_q <= tat_pkg::ACT_NONE; ovf_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ri_q <= ri_d; wi_q <= wi_d;
      act_q <= act_d; ovf_q <= ovf_d;
    end
  end

  wire last_e = (ri_q + 1'b1) >= cnt_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; ri_d = ri_q; wi_d = wi_q;
    act_d = act_q; ovf_d = ovf_q;
    cmd_o = '0;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    o_vv_o = 1'b0; o_fin_o = 1'b0; o_ovf_o = 1'b0; o_last_o = 1'b0;
    unique case (st_q)
      tat_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          act_d = tat_pkg::action_e'(action_i);
          ri_d = '0; wi_d = '0; ovf_d = 1'b0;
          if (action_i == tat_pkg::ACT_PUSH) begin
            st_d = tat_pkg::ST_SHIFT;
          end else if (action_i == tat_pkg::ACT_NONE || cnt_q == '0) begin
            st_d = tat_pkg::ST_RESP;
          end else begin
            st_d = tat_pkg::ST_RD;
          end
        end
      end
      tat_pkg::ST_RD: begin
        cmd_o.rd = 1'b1;
        st_d = tat_pkg::ST_RDW;
      end
      tat_pkg::ST_RDW: begin
        cmd_o.load_e = 1'b1;
        st_d = (act_q == tat_pkg::ACT_UPDATE) ? tat_pkg::ST_DIV : tat_pkg::ST_SHIFT;
        if (act_q == tat_pkg::ACT_REMOVE && sts_i.tag_hit) begin
          // Dropped entry: move on without writing it back.
          ri_d = ri_q + 1'b1;
          if (last_e) begin
            cnt_d = wi_q; st_d = tat_pkg::ST_RESP;
          end else begin
            st_d = tat_pkg::ST_RD;
          end
        end
      end
      tat_pkg::ST_DIV: begin
        if (sts_i.done_e || sts_i.div_done) st_d = tat_pkg::ST_MUL1;
        else cmd_o.div_step = 1'b1;
      end
      tat_pkg::ST_MUL1: begin cmd_o.mul1 = 1'b1; st_d = tat_pkg::ST_MUL2; end
      tat_pkg::ST_MUL2: begin cmd_o.mul2 = 1'b1; st_d = tat_pkg::ST_MUL3; end
      tat_pkg::ST_MUL3: begin cmd_o.mul3 = 1'b1; st_d = tat_pkg::ST_EMIT; end
      tat_pkg::ST_EMIT: begin
        out_valid_o = 1'b1; o_vv_o = 1'b1;
        o_fin_o = sts_i.done_e; o_last_o = last_e;
        if (out_ready_i) begin
          ri_d = ri_q + 1'b1;
          if (!sts_i.done_e) begin
            cmd_o.shift_wr = 1'b1; wi_d = wi_q + 1'b1;
          end
          if (last_e) begin
            cnt_d = sts_i.done_e ? wi_q : wi_q + 1'b1;
            st_d = tat_pkg::ST_IDLE;
          end else begin
            st_d = tat_pkg::ST_RD;
          end
        end
      end
      tat_pkg::ST_SHIFT: begin
        if (act_q == tat_pkg::ACT_PUSH) begin
          if (cnt_q >= (IW+1)'(DEPTH)) ovf_d = 1'b1;
          else begin cmd_o.wr_push = 1'b1; cnt_d = cnt_q + 1'b1; end
          st_d = tat_pkg::ST_RESP;
        end else begin
          // Kept entry of a removal: compact it.
          cmd_o.shift_wr = 1'b1; wi_d = wi_q + 1'b1; ri_d = ri_q + 1'b1;
          if (last_e) begin
            cnt_d = wi_q + 1'b1; st_d = tat_pkg::ST_RESP;
          end else begin
            st_d = tat_pkg::ST_RD;
          end
        end
      end
      tat_pkg::ST_RESP: begin
        out_valid_o = 1'b1; o_ovf_o = ovf_q; o_last_o = 1'b1;
        if (out_ready_i) st_d = tat_pkg::ST_IDLE;
      end
      default: st_d = tat_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (IW+1)'(DEPTH))
    else $error("entry count above depth");
  a_wi: assert property (@(posedge clk_i) disable iff (!rst_ni) wi_q <= ri_q)
    else $error("write index passed read index");
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_push |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not grow table");
`endif
endmodule
`default_nettype wire

// ----- test/tween_animation_table_tb.sv -----
// Testbench for tween_animation_table: push, update and remove transactions with
// a self-checking smoothstep predictor. Depends on tat_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tween_animation_table_tb;

  localparam int unsigned Depth = 16;
  localparam longint unsigned CycleLimit = 2000000;

  typedef struct {
    logic [7:0]  tag;
    logic [7:0]  subject;
    logic [31:0] start;
    logic [15:0] duration;
    logic [31:0] init_v;
    logic [31:0] targ_v;
  } tween_t;

  typedef struct {
    logic        valid_value;
    logic [7:0]  subject;
    logic [31:0] value;
    logic        finished;
    logic        overflow;
    logic        last;
  } anim_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // Shadow copy of the tween table and the queue of expected results.
  tween_t       tween_shadow[Depth];
  int unsigned  tween_count;
  anim_result_t pending_results[$];

  int unsigned  error_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  finished_seen = 0;
  int unsigned  overflow_seen = 0;
  longint unsigned cycle_count = 0;
  bit           calm = 1'b0;     // no idling on either side
  bit           hold_sink = 1'b0;
  logic [31:0]  tick_base = 32'd1000;

  tween_animation_table #(.TABLE_DEPTH(Depth)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("** tween_animation_table: FAILED **");
      $finish;
    end
  end

  // Eased value of one tween at the given tick.
  function automatic logic [31:0] eased_value(tween_t tw, logic [31:0] now_t);
    logic [31:0]     elapsed;
    longint unsigned frac;
    longint unsigned shape;
    longint signed   diff;
    longint signed   scaled;
    elapsed = (now_t >= tw.start) ? now_t - tw.start : 32'd0;
    frac    = ({32'd0, elapsed} << 16) / tw.duration;
    shape   = (frac * frac * (64'd196608 - 2 * frac)) >> 32;
    diff    = longint'(signed'(tw.targ_v)) - longint'(signed'(tw.init_v));
    scaled  = (diff * longint'(shape)) >>> 16;
    return 32'(longint'(signed'(tw.init_v)) + scaled);
  endfunction

  function automatic void queue_plain(logic ovf);
    anim_result_t r;
    r = '{1'b0, 8'd0, 32'd0, 1'b0, ovf, 1'b1};
    pending_results.push_back(r);
  endfunction

  // Applies one accepted transaction to the shadow table and queues its results.
  function automatic void predict_tweens(tat_pkg::action_e act, logic [7:0] tag,
                                         logic [7:0] subj,
                                         logic [31:0] init_v, logic [31:0] targ_v,
                                         logic [31:0] tm, logic [15:0] dur);
    int unsigned  i;
    int unsigned  j;
    tween_t       tw;
    anim_result_t r;
    case (act)
      tat_pkg::ACT_PUSH: begin
        if (tween_count >= Depth) begin
          queue_plain(1'b1);
        end else begin
          tween_shadow[tween_count] = '{tag, subj, tm, dur, init_v, targ_v};
          tween_count++;
          queue_plain(1'b0);
        end
      end
      tat_pkg::ACT_REMOVE: begin
        i = 0;
        while (i < tween_count) begin
          if (tween_shadow[i].tag == tag) begin
            for (j = i; j + 1 < tween_count; j++) tween_shadow[j] = tween_shadow[j + 1];
            tween_count--;
          end else begin
            i++;
          end
        end
        queue_plain(1'b0);
      end
      tat_pkg::ACT_UPDATE: begin
        if (tween_count == 0) begin
          queue_plain(1'b0);
        end else begin
          i = 0;
          while (i < tween_count) begin
            tw = tween_shadow[i];
            if (tw.duration == 0 || ((tm >= tw.start) ? tm - tw.start : 32'd0) >= tw.duration)
            begin
              r = '{1'b1, tw.subject, tw.targ_v, 1'b1, 1'b0, 1'b0};
              for (j = i; j + 1 < tween_count; j++) tween_shadow[j] = tween_shadow[j + 1];
              tween_count--;
            end else begin
              r = '{1'b1, tw.subject, eased_value(tw, tm), 1'b0, 1'b0, 1'b0};
              i++;
            end
            pending_results.push_back(r);
          end
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
      end
      default: queue_plain(1'b0);
    endcase
  endfunction

  // Sends one item; the time argument fills both the start tick and the current
  // tick fields. Returns at the clock edge of the transaction.
  task automatic send_item(tat_pkg::action_e act, logic [7:0] tag, logic [7:0] subj,
                           logic [31:0] init_v, logic [31:0] targ_v,
                           logic [31:0] tm, logic [15:0] dur);
    logic [167:0] word;
    int           gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 32) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[1:0]     = act;
    word[9:2]     = tag;
    word[17:10]   = subj;
    word[49:18]   = init_v;
    word[81:50]   = targ_v;
    word[113:82]  = tm;
    word[129:114] = dur;
    word[161:130] = tm;
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tweens(act, tag, subj, init_v, targ_v, tm, dur);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: random stalls, optional long hold-off, and the result check.
  always @(posedge clk_i) begin
    anim_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result subject=%0d value=%h", $time,
                 m_axis_tdata[7:0], m_axis_tdata[39:8]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.finished) finished_seen++;
        if (want.overflow) overflow_seen++;
        if (m_axis_tdata[7:0] !== want.subject || m_axis_tdata[39:8] !== want.value ||
            m_axis_tuser !== {want.overflow, want.finished, want.valid_value} ||
            m_axis_tlast !== want.last) begin
          $display("%0t: mismatch expected subj=%0d val=%h ovf/fin/vld=%b%b%b last=%b",
                   $time, want.subject, want.value, want.overflow, want.finished,
                   want.valid_value, want.last);
          $display("%0t:          actual   subj=%0d val=%h ovf/fin/vld=%b last=%b",
                   $time, m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tuser,
                   m_axis_tlast);
          error_count++;
        end
      end
    end
    m_axis_tready <= !hold_sink && (calm || $urandom_range(99) >= 32);
  end

  // Directed corners: empty update, unused action, field extremes, zero duration,
  // negative elapsed time and mid-way easing.
  task automatic test_corners();
    send_item(tat_pkg::ACT_UPDATE, 8'd0, 8'd0, '0, '0, 32'd5, 16'd0);
    send_item(tat_pkg::ACT_NONE, 8'hFF, 8'hFF, '1, '1, '1, '1);
    send_item(tat_pkg::ACT_PUSH, 8'hFF, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd100,
              16'hFFFF);
    send_item(tat_pkg::ACT_PUSH, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 32'd100, 16'd1);
    send_item(tat_pkg::ACT_PUSH, 8'h01, 8'h5A, 32'h0001_0000, 32'h000A_0000, 32'd0, 16'd0);
    send_item(tat_pkg::ACT_PUSH, 8'h02, 8'hA5, 32'hFFFF_0000, 32'h0003_8000, 32'hFFFF_FFF0,
              16'd40);
    send_item(tat_pkg::ACT_PUSH, 8'h03, 8'h11, 32'h0000_0000, 32'h0064_0000, 32'd200, 16'd10);
    // Elapsed below zero for every entry but the third, which has zero duration.
    send_item(tat_pkg::ACT_UPDATE, 8'd0, 8'd0, '0, '0, 32'd50, 16'd0);
    send_item(tat_pkg::ACT_UPDATE, 8'd0, 8'd0, '0, '0, 32'd205, 16'd0);
    send_item(tat_pkg::ACT_UPDATE, 8'd0, 8'd0, '0, '0, 32'hFFFF_FFFF, 16'd0);
    send_item(tat_pkg::ACT_REMOVE, 8'hFF, 8'd0, '0, '0, '0, 16'd0);
    send_item(tat_pkg::ACT_UPDATE, 8'd0, 8'd0, '0, '0, '1, 16'd0);
  endtask

  // Fill the table past its depth, then remove by tag and update the rest.
  task automatic test_full_table();
    for (int k = 0; k < Depth + 2; k++)
      send_item(tat_pkg::ACT_PUSH, 8'(k % 3), 8'(k), 32'(k) << 16, 32'(k * 7) << 16,
                32'd300, 16'(k + 2));
    send_item(tat_pkg::ACT_REMOVE, 8'd1, 8'd0, '0, '0, '0, 16'd0);
    send_item(tat_pkg::ACT_UPDATE, 8'd0, 8'd0, '0, '0, 32'd305, 16'd0);
    send_item(tat_pkg::ACT_REMOVE, 8'd0, 8'd0, '0, '0, '0, 16'd0);
    send_item(tat_pkg::ACT_REMOVE, 8'd2, 8'd0, '0, '0, '0, 16'd0);
  endtask

  // Random traffic: mostly pushes and advancing update ticks on a moving time base.
  task automatic test_random(int unsigned n_items);
    int unsigned pick;
    logic [15:0] dur;
    logic [31:0] tm;
    for (int unsigned k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        tm  = ($urandom_range(9) == 0) ? $urandom : tick_base + $urandom_range(0, 20) - 10;
        send_item(tat_pkg::ACT_PUSH, 8'($urandom_range(0, 3)), 8'($urandom), $urandom,
                  $urandom, tm, dur);
      end else if (pick < 85) begin
        tick_base = tick_base + $urandom_range(0, 15);
        tm = ($urandom_range(19) == 0) ? $urandom : tick_base;
        send_item(tat_pkg::ACT_UPDATE, 8'($urandom), 8'($urandom), $urandom, $urandom, tm,
                  16'($urandom));
      end else if (pick < 95) begin
        send_item(tat_pkg::ACT_REMOVE,
                  ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                  8'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
      end else begin
        send_item(tat_pkg::ACT_NONE, 8'($urandom), 8'($urandom), $urandom, $urandom,
                  $urandom, 16'($urandom));
      end
    end
  endtask

  // Long receiver hold-off while the sender keeps offering pushes and updates.
  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      begin
        for (int k = 0; k < 6; k++) begin
          send_item(tat_pkg::ACT_PUSH, 8'd9, 8'(k), $urandom, $urandom, tick_base, 16'd30);
          send_item(tat_pkg::ACT_UPDATE, 8'd0, 8'd0, '0, '0, tick_base + k, 16'd0);
        end
      end
    join
    send_item(tat_pkg::ACT_REMOVE, 8'd9, 8'd0, '0, '0, '0, 16'd0);
  endtask

  initial begin
    tween_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_full_table();
    test_random(45);
    calm = 1'b1;
    test_random(30);
    calm = 1'b0;
    test_backpressure();
    test_random(35);
    s_axis_tvalid <= 1'b0;
    drain_results();
    repeat (100) @(posedge clk_i);
    $display("Covered pushes, overflow, removes, easing updates and stalls: %0d results,",
             results_seen);
    $display("%0d finished tweens, %0d dropped pushes, %0d errors.", finished_seen,
             overflow_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** tween_animation_table: PASSED **");
    end else begin
      $display("** tween_animation_table: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/tat_pkg.sv
rtl/core/tat_datapath.sv
rtl/core/tat_ctrl.sv
rtl/core/tween_animation_table.sv
test/tween_animation_table_tb.sv
